FILE: hw/rtl/gap_buffer_edit_engine_assert.svh
// Assertion macros for the gap buffer edit engine.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef GAP_BUFFER_EDIT_ENGINE_ASSERT_SVH
`define GAP_BUFFER_EDIT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, ignoring cycles in reset
`define GBE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising edge, reset included
`define GBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GBE_ASSERT(lbl, clk, rstn, prop, msg)
`define GBE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/gbe_pkg.sv
// Shared types and constants for the gap buffer edit engine.
// No dependencies; used by gap_buffer_edit_engine.
`default_nettype none

package gbe_pkg;

  // Default store size in characters
  localparam int unsigned CAPACITY_DEF = 1024;

  // Fixed field widths of the item streams
  localparam int unsigned OP_W   = 2;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned ST_W   = 2;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  // Operation selector carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  // Result status
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

`default_nettype wire

FILE: hw/rtl/gbe_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module gbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; hold the last data while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gap_buffer_edit_engine.sv
// Flow: a read or a rejected item posts its result from the read-wait or edit state; an insert
// or delete first moves the gap by n characters (0 to CAPACITY), then applies the edit.
// No new item is taken before the result is posted; the gap moves one character per cycle through
// the single write port of the text store. A result held in the output register stalls the next one.
// Reset: asynchronous, active low; the gap spans the whole store (empty text). The store
// itself is not cleared.
// Top level of the gap buffer edit engine; depends on gbe_pkg, gbe_ram and the assert header.
`default_nettype none

`include "gap_buffer_edit_engine_assert.svh"

module gap_buffer_edit_engine #(
  parameter int unsigned CAPACITY = gbe_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: position[10:0], end_position[21:11], character[29:22], zero pad[31:30]
  input  wire logic [gbe_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [gbe_pkg::OP_W-1:0]        s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: read_character[7:0], text_length[18:8], status[20:19], zero pad[23:21]
  output logic      [gbe_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = ((PW > gbe_pkg::POS_W) ? PW : gbe_pkg::POS_W) + 1;

  localparam int unsigned POS_LO  = 0;
  localparam int unsigned ENDP_LO = POS_LO + gbe_pkg::POS_W;
  localparam int unsigned CHAR_LO = ENDP_LO + gbe_pkg::POS_W;
  localparam int unsigned LEN_LO  = gbe_pkg::CHAR_W;
  localparam int unsigned ST_LO   = LEN_LO + gbe_pkg::LEN_W;
  localparam int unsigned OUT_USED = ST_LO + gbe_pkg::ST_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_EDIT,
    S_RDWAIT
  } state_e;

  state_e                        state_q, state_d;
  logic [PW-1:0]                 gap_first_q, gap_first_d;
  logic [PW-1:0]                 gap_after_q, gap_after_d;
  logic [PW-1:0]                 dest_q, dest_d;
  logic [PW-1:0]                 del_q, del_d;
  logic [gbe_pkg::CHAR_W-1:0]    char_q, char_d;
  gbe_pkg::op_e                  op_q, op_d;
  gbe_pkg::status_e              status_q, status_d;
  logic                          pend_q, pend_d;
  logic [AW-1:0]                 pend_addr_q, pend_addr_d;
  logic                          out_valid_q, out_valid_d;
  logic [gbe_pkg::CHAR_W-1:0]    out_char_q, out_char_d;
  logic [gbe_pkg::LEN_W-1:0]     out_len_q, out_len_d;
  gbe_pkg::status_e              out_status_q, out_status_d;

  // Input fields
  gbe_pkg::op_e                  op_in;
  logic [gbe_pkg::POS_W-1:0]     pos_in;
  logic [gbe_pkg::POS_W-1:0]     endp_in;
  logic [gbe_pkg::CHAR_W-1:0]    char_in;
  logic [XW-1:0]                 pos_x, endp_x, len_x, len_edit_x;
  logic [PW-1:0]                 gap_size, phys, gf_dec, ga_dec, gf_edit;

  // Store ports
  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [gbe_pkg::CHAR_W-1:0]    mem_wdata, mem_rdata;

  logic                          in_acc, out_free;

  assign op_in   = gbe_pkg::op_e'(s_axis_tuser);
  assign pos_in  = s_axis_tdata[POS_LO +: gbe_pkg::POS_W];
  assign endp_in = s_axis_tdata[ENDP_LO +: gbe_pkg::POS_W];
  assign char_in = s_axis_tdata[CHAR_LO +: gbe_pkg::CHAR_W];

  assign pos_x    = XW'(pos_in);
  assign endp_x   = XW'(endp_in);
  assign gap_size = gap_after_q - gap_first_q;
  assign len_x    = XW'(CAPACITY) - XW'(gap_size);
  assign phys     = (pos_x[PW-1:0] < gap_first_q) ? pos_x[PW-1:0] : pos_x[PW-1:0] + gap_size;
  assign gf_dec   = gap_first_q - 1'b1;
  assign ga_dec   = gap_after_q - 1'b1;

  // Gap start once the edit is applied
  assign gf_edit    = (op_q == gbe_pkg::OP_INSERT) ? gap_first_q + 1'b1 : gap_first_q - del_q;
  assign len_edit_x = XW'(CAPACITY) - XW'(gap_after_q - gf_edit);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Sequencer and copy datapath
  always_comb begin
    state_d      = state_q;
    gap_first_d  = gap_first_q;
    gap_after_d  = gap_after_q;
    dest_d       = dest_q;
    del_d        = del_q;
    char_d       = char_q;
    op_d         = op_q;
    status_d     = status_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_char_d   = out_char_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;
    mem_re       = 1'b0;
    mem_raddr    = phys[AW-1:0];
    mem_we       = pend_q;
    mem_waddr    = pend_addr_q;
    mem_wdata    = mem_rdata;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d     = op_in;
          char_d   = char_in;
          dest_d   = pos_x[PW-1:0];
          del_d    = '0;
          status_d = gbe_pkg::ST_OK;
          state_d  = S_EDIT;
          case (op_in)
            gbe_pkg::OP_READ: begin
              if (pos_x >= len_x) begin
                status_d = gbe_pkg::ST_RANGE;
              end else begin
                mem_re  = 1'b1;
                state_d = S_RDWAIT;
              end
            end
            gbe_pkg::OP_INSERT: begin
              if (pos_x > len_x) begin
                status_d = gbe_pkg::ST_RANGE;
              end else if (gap_first_q >= gap_after_q) begin
                status_d = gbe_pkg::ST_FULL;
              end else begin
                state_d = S_MOVE;
              end
            end
            gbe_pkg::OP_DELETE: begin
              if (pos_x > endp_x || endp_x > len_x) begin
                status_d = gbe_pkg::ST_RANGE;
              end else begin
                dest_d  = endp_x[PW-1:0];
                del_d   = endp_x[PW-1:0] - pos_x[PW-1:0];
                state_d = S_MOVE;
              end
            end
            default: begin
              status_d = gbe_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_MOVE: begin
        // Issue one copy read a cycle; its write lands in the next cycle
        if (gap_first_q > dest_q) begin
          mem_re      = 1'b1;
          mem_raddr   = gf_dec[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = ga_dec[AW-1:0];
          gap_first_d = gf_dec;
          gap_after_d = ga_dec;
        end else if (gap_first_q < dest_q && gap_after_q < PW'(CAPACITY)) begin
          mem_re      = 1'b1;
          mem_raddr   = gap_after_q[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = gap_first_q[AW-1:0];
          gap_first_d = gap_first_q + 1'b1;
          gap_after_d = gap_after_q + 1'b1;
        end else begin
          state_d = S_EDIT;
        end
      end

      S_EDIT: begin
        // Apply the edit and post the result once the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_char_d   = '0;
          out_status_d = status_q;
          out_len_d    = len_x[gbe_pkg::LEN_W-1:0];
          state_d      = S_IDLE;
          if (status_q == gbe_pkg::ST_OK) begin
            gap_first_d = gf_edit;
            out_len_d   = len_edit_x[gbe_pkg::LEN_W-1:0];
            if (op_q == gbe_pkg::OP_INSERT) begin
              mem_we    = 1'b1;
              mem_waddr = gap_first_q[AW-1:0];
              mem_wdata = char_q;
            end
          end
        end
      end

      S_RDWAIT: begin
        // Read data is held by the store until the next read
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_char_d   = mem_rdata;
          out_status_d = gbe_pkg::ST_OK;
          out_len_d    = len_x[gbe_pkg::LEN_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, pointers and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      gap_first_q  <= '0;
      gap_after_q  <= PW'(CAPACITY);
      dest_q       <= '0;
      del_q        <= '0;
      char_q       <= '0;
      op_q         <= gbe_pkg::OP_READ;
      status_q     <= gbe_pkg::ST_OK;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      out_char_q   <= '0;
      out_len_q    <= '0;
      out_status_q <= gbe_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      gap_first_q  <= gap_first_d;
      gap_after_q  <= gap_after_d;
      dest_q       <= dest_d;
      del_q        <= del_d;
      char_q       <= char_d;
      op_q         <= op_d;
      status_q     <= status_d;
      pend_q       <= pend_d;
      pend_addr_q  <= pend_addr_d;
      out_valid_q  <= out_valid_d;
      out_char_q   <= out_char_d;
      out_len_q    <= out_len_d;
      out_status_q <= out_status_d;
    end
  end

  // Text store
  gbe_ram #(
    .WIDTH (gbe_pkg::CHAR_W),
    .DEPTH (CAPACITY)
  ) u_text_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(gbe_pkg::OUT_DATA_W - OUT_USED)'(0), out_status_q, out_len_q,
                          out_char_q};

  `GBE_ASSERT(a_gap_order, clk_i, rst_ni, gap_first_q <= gap_after_q, "gap start passed gap end")
  `GBE_ASSERT(a_gap_bound, clk_i, rst_ni, gap_after_q <= PW'(CAPACITY), "gap end beyond store")
  `GBE_ASSERT(a_no_write_clash, clk_i, rst_ni, (state_q == S_EDIT) |-> !pend_q,
              "copy write still pending at edit")
  `GBE_ASSERT(a_pend_in_move, clk_i, rst_ni,
              pend_q |-> ($past(state_q) == S_MOVE), "copy write without a move")
  `GBE_ASSERT(a_busy_no_ready, clk_i, rst_ni,
              (in_acc && s_axis_tuser == gbe_pkg::OP_INSERT) |=> !s_axis_tready,
              "ready while an insert is in work")

endmodule

`default_nettype wire
